FILE: design/tma_pkg.sv
// Package for the trimmed moving average block.
// Holds widths, register indexes, reset values, the controller state type
// and the scan control struct. No dependencies.
package tma_pkg;

  localparam int SAMPLE_W       = 24;
  localparam int REG_W          = 16;
  localparam int WEIGHT_W       = 40;
  localparam int CFG_IDX_W      = 8;
  localparam int DEF_WINDOW_LEN = 34;

  localparam logic [REG_W-1:0] GAIN_RESET   = 16'd14764;
  localparam logic [REG_W-1:0] OFFSET_RESET = 16'd1311;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } tma_state_e;

  typedef struct packed {
    logic step;
    logic first;
  } scan_ctrl_t;

endpackage

FILE: design/tma_cell.sv
// One window cell: a sample register that takes its neighbor's value when enabled.
// Depends on tma_pkg for the sample width.
module tma_cell
  import tma_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [SAMPLE_W-1:0] d_i,
  output logic [SAMPLE_W-1:0] q_o
);

  logic [SAMPLE_W-1:0] val_q;
  logic [SAMPLE_W-1:0] val_d;

  assign val_d = en_i ? d_i : val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

FILE: design/tma_scan.sv
// Scan accumulator: sums the samples leaving the head cell and tracks max and min.
// Depends on tma_pkg for the sample width and the scan control struct.
module tma_scan
  import tma_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scan_ctrl_t          ctrl_i,
  input  logic [SAMPLE_W-1:0] value_i,
  output logic [SUM_W-1:0]    sum_o,
  output logic [SAMPLE_W-1:0] max_o,
  output logic [SAMPLE_W-1:0] min_o
);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] max_q, max_d;
  logic [SAMPLE_W-1:0] min_q, min_d;

  always_comb begin
    sum_d = sum_q;
    max_d = max_q;
    min_d = min_q;
    if (ctrl_i.step) begin
      if (ctrl_i.first) begin
        // seed from the first entry so the min search starts there
        sum_d = SUM_W'(value_i);
        max_d = value_i;
        min_d = value_i;
      end else begin
        sum_d = sum_q + SUM_W'(value_i);
        if (value_i > max_q) max_d = value_i;
        if (value_i < min_q) min_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      max_q <= '0;
      min_q <= '0;
    end else begin
      sum_q <= sum_d;
      max_q <= max_d;
      min_q <= min_d;
    end
  end

  assign sum_o = sum_q;
  assign max_o = max_q;
  assign min_o = min_q;

endmodule

FILE: design/tma_div.sv
// Divider by the constant WINDOW_LEN - 2: multiplies by a rounded-up reciprocal
// in two halves, low then high, and keeps the high bits of the product.
// Depends on tma_pkg for the sample width; quotient is known to fit SAMPLE_W bits.
module tma_div
  import tma_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SUM_W-1:0]    dividend_i,
  output logic                done_o,
  output logic [SAMPLE_W-1:0] quotient_o
);

  localparam int DIVISOR = WINDOW_LEN - 2;
  localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W = SUM_W + 1;
  localparam int HALF_W  = (RECIP_W + 1) / 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int LO_W    = SUM_W + HALF_W;
  localparam int HI_W    = PROD_W - HALF_W;

  // ceil(2^SHIFT / DIVISOR) keeps the truncated product exact for every dividend
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0]        RECIP    = RECIP_64[RECIP_W-1:0];
  localparam logic [HALF_W-1:0]         RECIP_LO = RECIP[HALF_W-1:0];
  localparam logic [RECIP_W-HALF_W-1:0] RECIP_HI = RECIP[RECIP_W-1:HALF_W];

  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  logic [SUM_W-1:0]  num_q, num_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [LO_W-1:0]   part_lo;
  logic [HI_W-1:0]   part_hi;

  assign part_lo = LO_W'(num_q) * LO_W'(RECIP_LO);
  assign part_hi = HI_W'(num_q) * HI_W'(RECIP_HI);

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    num_d   = num_q;
    prod_d  = prod_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      num_d   = dividend_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        prod_d  = PROD_W'(part_lo);
        phase_d = 1'b1;
      end else begin
        // add the upper half of the reciprocal in place and finish
        prod_d = prod_q + {part_hi, {HALF_W{1'b0}}};
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    prod_q <= prod_d;
  end

  assign done_o     = busy_q && phase_q;
  assign quotient_o = prod_q[SHIFT +: SAMPLE_W];

endmodule

FILE: design/trimmed_moving_average.sv
// Trimmed moving average top level: cell chain, scan accumulator, divider, scaling.
// Depends on tma_pkg, tma_cell, tma_scan and tma_div.
//
// - Input channel (in_valid_i / in_stall_o, sample_i) takes one sample per
//   transaction. The sample shifts into a chain of WINDOW_LEN cells and the
//   oldest drops out.
// - The chain then rotates once around while the head cell feeds the
//   accumulator (sum, max, min). ST_TRIM then drops the extremes, ST_DIV runs
//   the constant divider, ST_MUL scales by gain and offset and ST_DONE loads
//   the output register.
// - in_stall_o is high while an item is in flight, so the next sample is
//   accepted only after the previous result has been loaded for output.
// - Output channel (out_valid_o / out_stall_i) carries trimmed_mean_o and
//   weight_q16_o. A stalled result waits in the output register; the next
//   sample is accepted and processed meanwhile, and only the final load holds.
// - Config channel (cfg_valid_i / cfg_ready_o) writes gain (index 0) and offset
//   (index 1); other indexes are ignored. Ready is always high.
// - Reset clears the window to zero samples and restores gain and offset.
module trimmed_moving_average
  import tma_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  trimmed_mean_o,
  output logic [WEIGHT_W-1:0]  weight_q16_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i
);

  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW_LEN - 1);

  tma_state_e          state_q, state_d;
  logic [CNT_W-1:0]    scan_cnt_q, scan_cnt_d;
  logic [REG_W-1:0]    gain_q, offset_q;
  logic [WEIGHT_W-1:0] prod_q, prod_d;
  logic [SAMPLE_W-1:0] mean_q, mean_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_mean_q;
  logic [WEIGHT_W-1:0] out_weight_q;

  logic                accept;
  logic                shift_en;
  logic                div_start;
  logic                div_done;
  logic                out_load;
  scan_ctrl_t          scan_ctrl;
  logic [SAMPLE_W-1:0] cell_q [WINDOW_LEN];
  logic [SAMPLE_W-1:0] tail_d;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] win_max, win_min;
  logic [SUM_W-1:0]    trimmed;
  logic [SAMPLE_W-1:0] quotient;

  assign accept   = in_valid_i && !in_stall_o;
  assign shift_en = accept || (state_q == ST_SCAN);
  // load a new sample on accept, otherwise rotate the head back to the tail
  assign tail_d   = (state_q == ST_IDLE) ? sample_i : cell_q[0];

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    if (g == WINDOW_LEN - 1) begin : g_tail
      tma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (shift_en),
        .d_i    (tail_d),
        .q_o    (cell_q[g])
      );
    end else begin : g_body
      tma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (shift_en),
        .d_i    (cell_q[g+1]),
        .q_o    (cell_q[g])
      );
    end
  end

  assign scan_ctrl.step  = (state_q == ST_SCAN);
  assign scan_ctrl.first = (scan_cnt_q == '0);

  tma_scan #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .value_i (cell_q[0]),
    .sum_o   (sum),
    .max_o   (win_max),
    .min_o   (win_min)
  );

  assign trimmed   = sum - SUM_W'(win_max) - SUM_W'(win_min);
  assign div_start = (state_q == ST_TRIM);

  tma_div #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (trimmed),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    prod_d     = prod_q;
    mean_d     = mean_q;
    out_load   = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == LAST_CNT) state_d = ST_TRIM;
      end
      ST_TRIM: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_MUL;
      end
      ST_MUL: begin
        mean_d  = quotient;
        prod_d  = WEIGHT_W'(quotient) * WEIGHT_W'(gain_q) + WEIGHT_W'(offset_q);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is empty or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mean_q <= mean_d;
    if (out_load) begin
      out_mean_q   <= mean_q;
      out_weight_q <= prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GAIN_RESET;
      offset_q <= OFFSET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_GAIN) gain_q <= cfg_data_i;
      if (cfg_index_i == REG_OFFSET) offset_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign trimmed_mean_o = out_mean_q;
  assign weight_q16_o   = out_weight_q;

  a_accept_then_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (in_stall_o && state_q == ST_SCAN && scan_cnt_q == '0))
    else $error("accepted sample did not start a scan");

  a_scan_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_cnt_q <= LAST_CNT))
    else $error("scan counter ran past the window");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for trimmed_moving_average: directed and random load-cell samples
// checked against an in-bench window, trim, divide and calibration model.
// Depends on tma_pkg and the trimmed_moving_average RTL.
module tb_top;
  import tma_pkg::*;

  localparam int WIN         = DEF_WINDOW_LEN;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 285;
  localparam int NUM_PHASES  = 6;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX      = '1;
  localparam logic [REG_W-1:0]     REG_MAX         = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = REG_OFFSET + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [WEIGHT_W-1:0] weight;
  } reading_t;

  typedef enum logic [2:0] {
    SHAPE_UNIFORM,
    SHAPE_RUN,
    SHAPE_HIGH,
    SHAPE_LOW,
    SHAPE_SPIKE
  } shape_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [SAMPLE_W-1:0]  sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]  trimmed_mean_o;
  logic [WEIGHT_W-1:0]  weight_q16_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0]     cfg_data_i  = '0;

  // Model state
  logic [SAMPLE_W-1:0] window_q [WIN];
  logic [REG_W-1:0]    gain_q;
  logic [REG_W-1:0]    offset_q;
  reading_t            pending_readings [$];

  int unsigned error_cnt  = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_ack   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pct  = 0;

  trimmed_moving_average #(
    .WINDOW_LEN(WIN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trimmed_mean_o (trimmed_mean_o),
    .weight_q16_o   (weight_q16_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Shift one sample in, drop one copy of each extreme and scale the mean.
  function automatic reading_t shift_and_trim(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    logic [WEIGHT_W-1:0] total;
    logic [WEIGHT_W-1:0] mean;
    reading_t            r;
    for (int k = 0; k < WIN - 1; k++) window_q[k] = window_q[k + 1];
    window_q[WIN - 1] = s;
    hi    = window_q[0];
    lo    = window_q[0];
    total = '0;
    for (int k = 0; k < WIN; k++) begin
      if (window_q[k] > hi) hi = window_q[k];
      if (window_q[k] < lo) lo = window_q[k];
      total += window_q[k];
    end
    total    = total - hi - lo;
    mean     = total / WEIGHT_W'(WIN - 2);
    r.mean   = mean[SAMPLE_W-1:0];
    r.weight = mean * gain_q + offset_q;
    return r;
  endfunction

  always @(posedge clk_i) begin : result_checker
    reading_t want;
    if (!rst_ni) begin
      foreach (window_q[k]) window_q[k] = '0;
      gain_q   = GAIN_RESET;
      offset_q = OFFSET_RESET;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          $error("unexpected result: trimmed_mean %h weight_q16 %h",
                 trimmed_mean_o, weight_q16_o);
          error_cnt++;
        end else begin
          want = pending_readings.pop_front();
          if (trimmed_mean_o !== want.mean) begin
            $error("trimmed_mean: expected %h, actual %h", want.mean, trimmed_mean_o);
            error_cnt++;
          end
          if (weight_q16_o !== want.weight) begin
            $error("weight_q16: expected %h, actual %h", want.weight, weight_q16_o);
            error_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) pending_readings.push_back(shift_and_trim(sample_i));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_GAIN) gain_q = cfg_data_i;
        else if (cfg_index_i == REG_OFFSET) offset_q = cfg_data_i;
      end
    end
  end

  // Receiver: random stall density that is redrawn at the end of each random-length
  // segment, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 60;
          default: stall_pct = 95;
        endcase
        stall_left = $urandom_range(50, 400);
      end else begin
        stall_left--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[trimmed_moving_average] ERROR");
      $finish;
    end
  end

  // Offer one sample and hold it until the transaction completes.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit paced);
    int unsigned gap;
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (paced) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (last) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Window still mostly reset zeros; reset calibration values.
  task automatic test_partial_window();
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    wait_idle();
  endtask

  // Repeated extremes: only one copy of max and min drops out.
  task automatic test_ties();
    repeat (5) send_sample(24'h123456, 1'b0);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b0);
    wait_idle();
  endtask

  // Extreme calibration, then writes to unmapped indexes that must not land.
  task automatic test_unmapped_index();
    write_reg(REG_GAIN, REG_MAX, 1'b0);
    write_reg(REG_OFFSET, REG_MAX, 1'b0);
    write_reg(REG_UNMAPPED_LO, '0, 1'b0);
    write_reg(REG_UNMAPPED_HI, '0, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample(24'h3C3C3C, 1'b0);
    send_sample(24'hC3C3C3, 1'b0);
    wait_idle();
  endtask

  // Long receiver hold-off while samples keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_req++;
    repeat (20) send_sample(SAMPLE_W'($urandom), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [REG_W-1:0]    gains   [NUM_PHASES] = '{GAIN_RESET, '0, REG_MAX, REG_MAX, '0, '0};
    logic [REG_W-1:0]    offsets [NUM_PHASES] = '{OFFSET_RESET, '0, REG_MAX, '0, REG_MAX, '0};
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] run_val;
    shape_e              shape;
    int unsigned         n;
    int unsigned         seg;
    int unsigned         r;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        write_reg(REG_GAIN, REG_W'($urandom), 1'b0);
        write_reg(REG_OFFSET, REG_W'($urandom), 1'b1);
      end else begin
        write_reg(REG_GAIN, gains[p], 1'b0);
        write_reg(REG_OFFSET, offsets[p], 1'b1);
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        shape = shape_e'($urandom_range(0, 4));
        seg   = $urandom_range(1, 50);
        case ($urandom_range(0, 2))
          0: run_val = SAMPLE_MAX;
          1: run_val = '0;
          default: run_val = SAMPLE_W'($urandom);
        endcase
        for (int j = 0; j < seg && n < PHASE_ITEMS; j++) begin
          case (shape)
            SHAPE_UNIFORM: s = SAMPLE_W'($urandom);
            SHAPE_RUN:     s = run_val;
            SHAPE_HIGH:    s = SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
            SHAPE_LOW:     s = SAMPLE_W'($urandom_range(0, 255));
            default: begin
              r = $urandom_range(0, 7);
              s = (r == 0) ? SAMPLE_MAX : (r == 1) ? '0 : run_val;
            end
          endcase
          send_sample(s, 1'b1);
          n++;
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_partial_window();
    test_ties();
    test_unmapped_index();
    test_backpressure();
    test_random_phases();
    if (error_cnt == 0 && pending_readings.size() == 0) begin
      $display("[trimmed_moving_average] OK");
    end else begin
      $display("[trimmed_moving_average] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/tma_pkg.sv
design/tma_cell.sv
design/tma_scan.sv
design/tma_div.sv
design/trimmed_moving_average.sv
verif/tb_top.sv
